### design/pid_duty_controller_core_macros.svh
// assertion macros for the pid duty controller
// used by pid_duty_controller_core; expects clk and rst_n in scope
`ifndef PID_DUTY_CONTROLLER_CORE_MACROS_SVH
`define PID_DUTY_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define PDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pdc_pkg.sv
// shared types, widths and helpers of the pid duty controller
// used by pdc_serial_mul and pid_duty_controller_core; no dependencies
package pdc_pkg;

  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 24;
  localparam int SCALE_W   = 16;
  localparam int GAIN_FRAC = 8;
  localparam int ACC_SHIFT = (DATA_W - 2) + GAIN_FRAC;
  localparam int ACC_W     = 40;
  localparam int PROD_W    = ACC_W + SCALE_W;
  localparam int QUO_W     = PROD_W - ACC_SHIFT;
  localparam int SUM_W     = QUO_W + 1;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic signed [DATA_W:0] TERM_POS = 17'sd16384;
  localparam logic signed [DATA_W:0] TERM_NEG = -17'sd16384;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY   = 3'd6;

  // term selector codes
  localparam logic [1:0] SEL_PROP  = 2'd0;
  localparam logic [1:0] SEL_INTEG = 2'd1;
  localparam logic [1:0] SEL_DERIV = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TERM_GO,
    S_TERM_RUN,
    S_SCALE_GO,
    S_SCALE_RUN,
    S_ADD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic signed_b;
  } mul_ctrl_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] product;
  } mul_stat_t;

  function automatic logic signed [DATA_W-1:0] clamp_unit(input logic signed [DATA_W:0] x);
    logic signed [DATA_W:0] r;
    if (x > TERM_POS) begin
      r = TERM_POS;
    end else if (x < TERM_NEG) begin
      r = TERM_NEG;
    end else begin
      r = x;
    end
    return r[DATA_W-1:0];
  endfunction

endpackage

### design/pid_duty_controller_core.sv
// pid duty controller top level: term update, control sequencer, limits
// depends on pdc_pkg, pdc_serial_mul and pid_duty_controller_core_macros.svh
//
//   channel   direction  word
//   in_       input      in_reference, in_sensor (signed q2.14)
//   out_      output     out_duty (signed integer)
//   cfg_      input      cfg_index, cfg_data (register write)
//
// a word is accepted only in the idle state, so an item is not taken until the
// previous one has left the final step; the serial multiplier runs four passes
// per item (three gain terms, then output scale).
// reset is synchronous and returns the gains, limits and state to defaults.
// a result waits in the output register while out_ready is low; the next
// word is taken meanwhile and is held in the final step until the slot frees.
module pid_duty_controller_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pdc_pkg::DATA_W-1:0]    in_reference,
  input  logic signed [pdc_pkg::DATA_W-1:0]    in_sensor,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pdc_pkg::DATA_W-1:0]    out_duty,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pdc_pkg::CFG_DAT_W-1:0]        cfg_data
);
  import pdc_pkg::*;
  `include "pid_duty_controller_core_macros.svh"

  // configuration
  logic signed [GAIN_W-1:0]  prop_gain_r;
  logic signed [GAIN_W-1:0]  integ_gain_r;
  logic signed [GAIN_W-1:0]  deriv_gain_r;
  logic                      speed_mode_r;
  logic [SCALE_W-1:0]        out_scale_r;
  logic signed [DATA_W-1:0]  max_duty_r;
  logic signed [DATA_W-1:0]  min_duty_r;

  // controller state
  logic signed [DATA_W-1:0]  prev_error_r;
  logic signed [DATA_W-1:0]  error_sum_r;
  logic signed [DATA_W-1:0]  last_duty_r;

  state_t                    state_r, state_nxt;
  logic [1:0]                term_sel_r;
  logic signed [DATA_W-1:0]  err_r, itg_r, dlt_r;
  logic                      ref_zero_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [QUO_W-1:0]   quo_r;
  logic signed [SUM_W-1:0]   tmp_r;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_duty_r;

  logic                      in_acc;
  logic                      fin_ok;
  mul_ctrl_t                 mul_ctrl;
  mul_stat_t                 mul_stat;
  logic signed [ACC_W-1:0]   mcand_c;
  logic [DATA_W-1:0]         mplier_c;
  logic signed [GAIN_W-1:0]  gain_sel_c;
  logic signed [DATA_W-1:0]  term_sel_c;

  logic signed [DATA_W:0]    diff_c, dlt_raw_c, itg_raw_c;
  logic signed [DATA_W-1:0]  err_c, dlt_c, itg_c;
  logic signed [QUO_W-1:0]   quo_c;
  logic signed [SUM_W-1:0]   base_c, quo_ext_c;
  logic signed [SUM_W-1:0]   max_ext_c, min_ext_c;
  logic signed [DATA_W-1:0]  duty_c;

  pdc_serial_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mul_ctrl),
    .mcand  (mcand_c),
    .mplier (mplier_c),
    .stat   (mul_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_TERM_GO;
      S_TERM_GO:   state_nxt = S_TERM_RUN;
      S_TERM_RUN: begin
        if (mul_stat.done) begin
          state_nxt = (term_sel_r == SEL_DERIV) ? S_SCALE_GO : S_TERM_GO;
        end
      end
      S_SCALE_GO:  state_nxt = S_SCALE_RUN;
      S_SCALE_RUN: if (mul_stat.done) state_nxt = S_ADD;
      S_ADD:       state_nxt = S_FINISH;
      S_FINISH:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready          = (state_r == S_IDLE);
    mul_ctrl.start    = (state_r == S_TERM_GO) || (state_r == S_SCALE_GO);
    mul_ctrl.signed_b = (state_r == S_TERM_GO);
    fin_ok            = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  end

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;

  // error terms, each clamped to +-1.0
  always_comb begin
    diff_c    = {in_reference[DATA_W-1], in_reference} - {in_sensor[DATA_W-1], in_sensor};
    err_c     = clamp_unit(diff_c);
    dlt_raw_c = {err_c[DATA_W-1], err_c} - {prev_error_r[DATA_W-1], prev_error_r};
    itg_raw_c = {error_sum_r[DATA_W-1], error_sum_r} + {err_c[DATA_W-1], err_c};
    dlt_c     = clamp_unit(dlt_raw_c);
    itg_c     = clamp_unit(itg_raw_c);
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (term_sel_r)
      SEL_PROP: begin
        gain_sel_c = prop_gain_r;
        term_sel_c = err_r;
      end
      SEL_INTEG: begin
        gain_sel_c = integ_gain_r;
        term_sel_c = itg_r;
      end
      SEL_DERIV: begin
        gain_sel_c = deriv_gain_r;
        term_sel_c = dlt_r;
      end
      default: begin
        gain_sel_c = '0;
        term_sel_c = '0;
      end
    endcase
    if (state_r == S_SCALE_GO) begin
      mcand_c  = acc_r;
      // position mode runs the same path with a scale of one
      mplier_c = speed_mode_r ? out_scale_r : DATA_W'(1);
    end else begin
      mcand_c  = {{(ACC_W-GAIN_W){gain_sel_c[GAIN_W-1]}}, gain_sel_c};
      mplier_c = term_sel_c;
    end
  end

  // truncation toward zero, base add, duty limits and zero duty for a zero reference
  always_comb begin
    quo_c     = mul_stat.product[PROD_W-1:ACC_SHIFT]
              + QUO_W'(mul_stat.product[PROD_W-1] && (|mul_stat.product[ACC_SHIFT-1:0]));
    base_c    = speed_mode_r ? {{(SUM_W-DATA_W){last_duty_r[DATA_W-1]}}, last_duty_r} : '0;
    quo_ext_c = {quo_r[QUO_W-1], quo_r};
    max_ext_c = {{(SUM_W-DATA_W){max_duty_r[DATA_W-1]}}, max_duty_r};
    min_ext_c = {{(SUM_W-DATA_W){min_duty_r[DATA_W-1]}}, min_duty_r};
    priority if (ref_zero_r) begin
      duty_c = '0;
    end else if (tmp_r >= max_ext_c) begin
      duty_c = max_duty_r;
    end else if (tmp_r <= min_ext_c) begin
      duty_c = min_duty_r;
    end else begin
      duty_c = tmp_r[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      speed_mode_r <= 1'b1;
      out_scale_r  <= SCALE_W'(1);
      max_duty_r   <= 16'sh7fff;
      min_duty_r   <= 16'sh8000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_r <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_r <= cfg_data[GAIN_W-1:0];
        REG_SPEED_MODE: speed_mode_r <= cfg_data[0];
        REG_OUT_SCALE:  out_scale_r  <= cfg_data[SCALE_W-1:0];
        REG_MAX_DUTY:   max_duty_r   <= cfg_data[DATA_W-1:0];
        REG_MIN_DUTY:   min_duty_r   <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      term_sel_r   <= SEL_PROP;
      prev_error_r <= '0;
      error_sum_r  <= '0;
      last_duty_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        err_r        <= err_c;
        dlt_r        <= dlt_c;
        itg_r        <= itg_c;
        prev_error_r <= err_c;
        error_sum_r  <= itg_c;
        ref_zero_r   <= (in_reference == '0);
        acc_r        <= '0;
        term_sel_r   <= SEL_PROP;
      end
      if ((state_r == S_TERM_RUN) && mul_stat.done) begin
        acc_r <= acc_r + mul_stat.product[ACC_W-1:0];
        if (term_sel_r != SEL_DERIV) begin
          term_sel_r <= term_sel_r + 2'd1;
        end
      end
      if ((state_r == S_SCALE_RUN) && mul_stat.done) begin
        quo_r <= quo_c;
      end
      if (state_r == S_ADD) begin
        tmp_r <= base_c + quo_ext_c;
      end
      if (fin_ok) begin
        out_duty_r  <= duty_c;
        last_duty_r <= duty_c;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `PDC_ASSERT_NOW(a_mul_done_in_run, mul_stat.done,
    (state_r == S_TERM_RUN) || (state_r == S_SCALE_RUN), "multiplier finished outside a run step")
  `PDC_ASSERT_NEXT(a_accept_starts_prop, in_acc,
    (state_r == S_TERM_GO) && (term_sel_r == SEL_PROP), "accepted word did not start the gain terms")
  `PDC_ASSERT_NOW(a_scale_after_deriv, state_r == S_SCALE_GO,
    term_sel_r == SEL_DERIV, "output scaling began before all three terms")
  `PDC_ASSERT_NOW(a_result_taken, $fell(out_valid_r) && $past(rst_n),
    $past(out_ready), "result word dropped without a handshake")

endmodule

### design/pdc_serial_mul.sv
// shift-add multiplier: one multiplier bit per cycle, lsb first
// depends on pdc_pkg; serves the gain terms and the output scaling
module pdc_serial_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pdc_pkg::mul_ctrl_t               ctrl,
  input  logic signed [pdc_pkg::ACC_W-1:0] mcand,
  input  logic [pdc_pkg::DATA_W-1:0]       mplier,
  output pdc_pkg::mul_stat_t               stat
);
  import pdc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  logic                     busy_r;
  logic                     done_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     sgn_r;
  logic signed [ACC_W-1:0]  mcand_r;
  logic [DATA_W-1:0]        mplier_r;
  logic signed [ACC_W:0]    hi_r;
  logic [DATA_W-1:0]        lo_r;

  logic                     last_c;
  logic signed [ACC_W:0]    mcand_ext;
  logic signed [ACC_W:0]    addend_c;
  logic signed [ACC_W:0]    sum_c;
  logic signed [ACC_W+DATA_W:0] full_c;

  always_comb begin
    last_c    = (cnt_r == CNT_LAST);
    mcand_ext = {mcand_r[ACC_W-1], mcand_r};
    // msb of a signed multiplier carries negative weight
    if (!mplier_r[0]) begin
      addend_c = '0;
    end else if (last_c && sgn_r) begin
      addend_c = -mcand_ext;
    end else begin
      addend_c = mcand_ext;
    end
    sum_c  = hi_r + addend_c;
    full_c = {hi_r, lo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        sgn_r    <= ctrl.signed_b;
        mcand_r  <= mcand;
        mplier_r <= mplier;
        hi_r     <= '0;
        lo_r     <= '0;
      end else if (busy_r) begin
        hi_r     <= sum_c >>> 1;
        lo_r     <= {sum_c[0], lo_r[DATA_W-1:1]};
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + 1'b1;
        if (last_c) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.done    = done_r;
  assign stat.product = full_c[PROD_W-1:0];

endmodule
